@@ sv/rfd_pkg.sv @@
`timescale 1ns / 1ps

package rfd_pkg;

	// payload bytes kept for the report: status, distances, energies and the light byte
	localparam int NUM_SLOTS  = 10;
	localparam int SLOT_W     = $clog2(NUM_SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_LIGHT = SLOT_W'(9);

	// payload byte positions
	localparam int PAY_STATUS  = 0;
	localparam int PAY_MOV_LO  = 1;
	localparam int PAY_MOV_HI  = 2;
	localparam int PAY_MOV_EN  = 3;
	localparam int PAY_STL_LO  = 4;
	localparam int PAY_STL_HI  = 5;
	localparam int PAY_STL_EN  = 6;
	localparam int PAY_DET_LO  = 7;
	localparam int PAY_DET_HI  = 8;
	localparam int PAY_LIGHT   = 9;

	// frame kinds
	localparam logic KIND_CMD  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	// work handed from the parser to the report builder
	typedef struct packed {
		logic              is_report;
		logic [SLOT_W-1:0] slot;
		logic [7:0]        data;
		logic              kind;
		logic              detect;
		logic              light;
	} op_t;

	localparam int OP_W = $bits(op_t);

	// one finished report
	typedef struct packed {
		logic        frame_kind;
		logic        target_seen;
		logic        mover_seen;
		logic        static_seen;
		logic [15:0] mover_range;
		logic [7:0]  mover_power;
		logic [15:0] static_range;
		logic [7:0]  static_power;
		logic [15:0] detect_range;
		logic [7:0]  light_level;
		logic        light_valid;
	} res_t;

	localparam int RES_W = $bits(res_t);

endpackage

@@ sv/rfd_fifo.sv @@
`timescale 1ns / 1ps

module rfd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill level past depth");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		wr && !rd |=> count_q == $past(count_q) + 1'b1)
		else $error("queue write lost");

endmodule

@@ sv/rfd_front.sv @@
`timescale 1ns / 1ps

module rfd_front
	import rfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] rx_byte,
	input  logic       op_full,
	output logic       full,
	output logic       op_push,
	output op_t        op
);

	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] ST_IDLE   = 5'd0;
	localparam logic [ST_W-1:0] ST_C_H1   = 5'd1;
	localparam logic [ST_W-1:0] ST_C_H2   = 5'd2;
	localparam logic [ST_W-1:0] ST_C_H3   = 5'd3;
	localparam logic [ST_W-1:0] ST_C_LENL = 5'd4;
	localparam logic [ST_W-1:0] ST_C_LENH = 5'd5;
	localparam logic [ST_W-1:0] ST_C_CMDL = 5'd6;
	localparam logic [ST_W-1:0] ST_C_CMDH = 5'd7;
	localparam logic [ST_W-1:0] ST_C_PAY  = 5'd8;
	localparam logic [ST_W-1:0] ST_C_F1   = 5'd9;
	localparam logic [ST_W-1:0] ST_C_F2   = 5'd10;
	localparam logic [ST_W-1:0] ST_C_F3   = 5'd11;
	localparam logic [ST_W-1:0] ST_C_F4   = 5'd12;
	localparam logic [ST_W-1:0] ST_D_H1   = 5'd13;
	localparam logic [ST_W-1:0] ST_D_H2   = 5'd14;
	localparam logic [ST_W-1:0] ST_D_H3   = 5'd15;
	localparam logic [ST_W-1:0] ST_D_LENL = 5'd16;
	localparam logic [ST_W-1:0] ST_D_LENH = 5'd17;
	localparam logic [ST_W-1:0] ST_D_TYPE = 5'd18;
	localparam logic [ST_W-1:0] ST_D_MARK = 5'd19;
	localparam logic [ST_W-1:0] ST_D_PAY  = 5'd20;
	localparam logic [ST_W-1:0] ST_D_F1   = 5'd21;
	localparam logic [ST_W-1:0] ST_D_F2   = 5'd22;
	localparam logic [ST_W-1:0] ST_D_F3   = 5'd23;
	localparam logic [ST_W-1:0] ST_D_F4   = 5'd24;

	localparam logic [7:0]  C_HDR0 = 8'hFD;
	localparam logic [7:0]  C_HDR1 = 8'hFC;
	localparam logic [7:0]  C_HDR2 = 8'hFB;
	localparam logic [7:0]  C_HDR3 = 8'hFA;
	localparam logic [7:0]  C_FTR0 = 8'h04;
	localparam logic [7:0]  C_FTR1 = 8'h03;
	localparam logic [7:0]  C_FTR2 = 8'h02;
	localparam logic [7:0]  C_FTR3 = 8'h01;
	localparam logic [7:0]  D_HDR0 = 8'hF4;
	localparam logic [7:0]  D_HDR1 = 8'hF3;
	localparam logic [7:0]  D_HDR2 = 8'hF2;
	localparam logic [7:0]  D_HDR3 = 8'hF1;
	localparam logic [7:0]  D_MARK = 8'hAA;
	localparam logic [7:0]  D_FTR0 = 8'hF8;
	localparam logic [7:0]  D_FTR1 = 8'hF7;
	localparam logic [7:0]  D_FTR2 = 8'hF6;
	localparam logic [7:0]  D_FTR3 = 8'hF5;
	localparam logic [15:0] CMD_REPORT = 16'hAA02;
	localparam logic [15:0] CMD_BASIC  = 16'h0101;
	localparam logic [15:0] C_LEN_MIN  = 16'd2;
	localparam logic [15:0] C_LEN_MAX  = 16'd66;
	localparam logic [15:0] D_LEN_MIN  = 16'd4;
	localparam logic [15:0] D_LEN_MAX  = 16'd60;
	localparam logic [6:0]  D_LEN_RPT  = 7'd11;
	localparam logic [6:0]  D_LEN_DET  = 7'd13;
	localparam logic [6:0]  IDX_DETECT = 7'd9;
	localparam logic [6:0]  IDX_LIGHT  = 7'd37;
	localparam logic [6:0]  IDX_LMIN   = 7'd38;
	localparam logic [7:0]  TYPE_LIGHT = 8'h01;

	logic [ST_W-1:0] state_q;
	logic [ST_W-1:0] state_d;
	logic [7:0]      len_lo_q;
	logic [6:0]      len_q;
	logic [6:0]      idx_q;
	logic [7:0]      cmd_lo_q;
	logic            cmd_ok_q;
	logic            type1_q;

	logic            accept;
	logic [15:0]     len_full;
	logic [6:0]      idx_inc;
	logic            pay_last;
	logic            op_v;
	op_t             op_d;

	assign full     = op_full;
	assign accept   = push && !op_full;
	assign len_full = {rx_byte, len_lo_q};
	assign idx_inc  = idx_q + 7'd1;
	assign pay_last = ({1'b0, idx_inc} + 8'd2) >= {1'b0, len_q};

	// next state and classification of the current beat
	always_comb begin
		state_d = ST_IDLE;
		op_v    = 1'b0;
		op_d    = '0;
		op_d.data = rx_byte;
		unique case (state_q) inside
			ST_IDLE: begin
				if (rx_byte == D_HDR0) begin
					state_d = ST_D_H1;
				end else if (rx_byte == C_HDR0) begin
					state_d = ST_C_H1;
				end
			end
			ST_C_H1: state_d = (rx_byte == C_HDR1) ? ST_C_H2 : ST_IDLE;
			ST_C_H2: state_d = (rx_byte == C_HDR2) ? ST_C_H3 : ST_IDLE;
			ST_C_H3: state_d = (rx_byte == C_HDR3) ? ST_C_LENL : ST_IDLE;
			ST_C_LENL: state_d = ST_C_LENH;
			ST_C_LENH: begin
				state_d = (len_full < C_LEN_MIN || len_full > C_LEN_MAX) ?
					ST_IDLE : ST_C_CMDL;
			end
			ST_C_CMDL: state_d = ST_C_CMDH;
			ST_C_CMDH: state_d = (len_q > 7'd2) ? ST_C_PAY : ST_C_F1;
			ST_C_PAY, ST_D_PAY: begin
				if (idx_q < IDX_DETECT) begin
					op_v      = 1'b1;
					op_d.slot = idx_q[SLOT_W-1:0];
				end else if (idx_q == IDX_LIGHT) begin
					op_v      = 1'b1;
					op_d.slot = SLOT_LIGHT;
				end
				if (state_q == ST_C_PAY) begin
					state_d = pay_last ? ST_C_F1 : ST_C_PAY;
				end else begin
					state_d = pay_last ? ST_D_F1 : ST_D_PAY;
				end
			end
			ST_C_F1: state_d = (rx_byte == C_FTR0) ? ST_C_F2 : ST_IDLE;
			ST_C_F2: state_d = (rx_byte == C_FTR1) ? ST_C_F3 : ST_IDLE;
			ST_C_F3: state_d = (rx_byte == C_FTR2) ? ST_C_F4 : ST_IDLE;
			ST_C_F4: begin
				if (rx_byte == C_FTR3 && idx_q >= IDX_DETECT && cmd_ok_q) begin
					op_v           = 1'b1;
					op_d.is_report = 1'b1;
					op_d.kind      = KIND_CMD;
					op_d.detect    = 1'b1;
					op_d.light     = 1'b0;
				end
			end
			ST_D_H1: state_d = (rx_byte == D_HDR1) ? ST_D_H2 : ST_IDLE;
			ST_D_H2: state_d = (rx_byte == D_HDR2) ? ST_D_H3 : ST_IDLE;
			ST_D_H3: state_d = (rx_byte == D_HDR3) ? ST_D_LENL : ST_IDLE;
			ST_D_LENL: state_d = ST_D_LENH;
			ST_D_LENH: begin
				state_d = (len_full < D_LEN_MIN || len_full > D_LEN_MAX) ?
					ST_IDLE : ST_D_TYPE;
			end
			ST_D_TYPE: state_d = ST_D_MARK;
			ST_D_MARK: state_d = (rx_byte == D_MARK) ? ST_D_PAY : ST_IDLE;
			ST_D_F1: state_d = (rx_byte == D_FTR0) ? ST_D_F2 : ST_IDLE;
			ST_D_F2: state_d = (rx_byte == D_FTR1) ? ST_D_F3 : ST_IDLE;
			ST_D_F3: state_d = (rx_byte == D_FTR2) ? ST_D_F4 : ST_IDLE;
			ST_D_F4: begin
				if (rx_byte == D_FTR3 && len_q >= D_LEN_RPT) begin
					op_v           = 1'b1;
					op_d.is_report = 1'b1;
					op_d.kind      = KIND_DATA;
					op_d.detect    = (len_q >= D_LEN_DET);
					op_d.light     = type1_q && (idx_q >= IDX_LMIN);
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign op_push = accept && op_v;
	assign op      = op_d;

	// parser state and frame context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			len_lo_q <= '0;
			len_q    <= '0;
			idx_q    <= '0;
			cmd_lo_q <= '0;
			cmd_ok_q <= 1'b0;
			type1_q  <= 1'b0;
		end else if (accept) begin
			state_q <= state_d;
			case (state_q) inside
				ST_C_LENL, ST_D_LENL: len_lo_q <= rx_byte;
				ST_C_LENH, ST_D_LENH: begin
					len_q <= len_full[6:0];
					idx_q <= '0;
				end
				ST_C_CMDL: cmd_lo_q <= rx_byte;
				ST_C_CMDH: begin
					cmd_ok_q <= ({rx_byte, cmd_lo_q} == CMD_REPORT) ||
						({rx_byte, cmd_lo_q} == CMD_BASIC);
				end
				ST_D_TYPE: type1_q <= (rx_byte == TYPE_LIGHT);
				ST_C_PAY, ST_D_PAY: idx_q <= idx_inc;
				default: ;
			endcase
		end
	end

	a_report_at_footer: assert property (@(posedge clk) disable iff (!arst_n)
		op_push && op.is_report |-> (state_q == ST_C_F4 || state_q == ST_D_F4))
		else $error("report raised outside a footer end");

	a_idle_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		op_push && op.is_report |=> state_q == ST_IDLE)
		else $error("parser did not return to idle after a report");

endmodule

@@ sv/rfd_back.sv @@
`timescale 1ns / 1ps

module rfd_back
	import rfd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic op_empty,
	input  op_t  op,
	input  logic res_full,
	output logic op_pop,
	output logic res_push,
	output res_t res
);

	logic [7:0] pay_q [NUM_SLOTS];
	logic [7:0] status;

	// a capture always drains; a report waits for room in the result queue
	assign op_pop   = !op_empty && (!op.is_report || !res_full);
	assign res_push = op_pop && op.is_report;
	assign status   = pay_q[PAY_STATUS];

	// captured payload bytes
	always_ff @(posedge clk) begin
		if (op_pop && !op.is_report) begin
			pay_q[op.slot] <= op.data;
		end
	end

	// report assembly
	always_comb begin
		res.frame_kind   = op.kind;
		res.target_seen  = (status != 8'd0);
		res.mover_seen   = (status == 8'd1) || (status == 8'd3);
		res.static_seen  = (status == 8'd2) || (status == 8'd3);
		res.mover_range  = {pay_q[PAY_MOV_HI], pay_q[PAY_MOV_LO]};
		res.mover_power  = pay_q[PAY_MOV_EN];
		res.static_range = {pay_q[PAY_STL_HI], pay_q[PAY_STL_LO]};
		res.static_power = pay_q[PAY_STL_EN];
		res.detect_range = op.detect ? {pay_q[PAY_DET_HI], pay_q[PAY_DET_LO]} : 16'd0;
		res.light_level  = op.light ? pay_q[PAY_LIGHT] : 8'd0;
		res.light_valid  = op.light;
	end

	a_report_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full && op.is_report && !op_empty)
		else $error("report pushed without room or without a report op");

endmodule

@@ sv/radar_frame_deframer.sv @@
`timescale 1ns / 1ps

// Radar serial frame deframer. Takes one received byte per clock on rx_byte
// (push/full) and parses command frames (FD FC FB FA ...) and data frames
// (F4 F3 F2 F1 ...), giving one target report on the result queue
// (empty/pop) for each qualifying frame after its last footer byte. The
// parser takes a byte every cycle while its op queue (OP_DEPTH entries) has
// room; payload bytes of interest and report requests pass through that
// queue to the report builder, which drains one op per cycle unless a report
// waits for room in the result queue. A report goes from the op queue into
// the result queue and then shows on the result ports, and the result queue
// holds RES_DEPTH reports; full rises only when the result side has stalled
// long enough to back up both queues.
module radar_frame_deframer
	import rfd_pkg::*;
#(
	parameter int OP_DEPTH  = 4,
	parameter int RES_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic        frame_kind,
	output logic        target_seen,
	output logic        mover_seen,
	output logic        static_seen,
	output logic [15:0] mover_range,
	output logic [7:0]  mover_power,
	output logic [15:0] static_range,
	output logic [7:0]  static_power,
	output logic [15:0] detect_range,
	output logic [7:0]  light_level,
	output logic        light_valid
);

	logic            op_push;
	logic            op_full;
	logic            op_empty;
	logic            op_pop;
	op_t             op_in;
	logic [OP_W-1:0] op_bits;
	op_t             op_head;
	logic            res_push;
	logic            res_full;
	logic            res_pop;
	res_t            res_in;
	logic [RES_W-1:0] res_bits;
	res_t            res_head;

	// parser
	rfd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.rx_byte (rx_byte),
		.op_full (op_full),
		.full    (full),
		.op_push (op_push),
		.op      (op_in)
	);

	// op queue between parser and builder
	rfd_fifo #(.WIDTH(OP_W), .DEPTH(OP_DEPTH)) u_op_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (op_push),
		.wr_data (op_in),
		.rd      (op_pop),
		.rd_data (op_bits),
		.full    (op_full),
		.empty   (op_empty)
	);

	assign op_head = op_t'(op_bits);

	// report builder
	rfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_empty (op_empty),
		.op       (op_head),
		.res_full (res_full),
		.op_pop   (op_pop),
		.res_push (res_push),
		.res      (res_in)
	);

	// result queue
	assign res_pop = pop && !empty;

	rfd_fifo #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_push),
		.wr_data (res_in),
		.rd      (res_pop),
		.rd_data (res_bits),
		.full    (res_full),
		.empty   (empty)
	);

	assign res_head     = res_t'(res_bits);
	assign frame_kind   = res_head.frame_kind;
	assign target_seen  = res_head.target_seen;
	assign mover_seen   = res_head.mover_seen;
	assign static_seen  = res_head.static_seen;
	assign mover_range  = res_head.mover_range;
	assign mover_power  = res_head.mover_power;
	assign static_range = res_head.static_range;
	assign static_power = res_head.static_power;
	assign detect_range = res_head.detect_range;
	assign light_level  = res_head.light_level;
	assign light_valid  = res_head.light_valid;

endmodule
